>>> src/acpu8_pkg.sv
// ----------------------------------------------------------------------------
// acpu8_pkg
// Shared widths, request kinds and opcodes of the 8-bit accumulator processor.
// ----------------------------------------------------------------------------
package acpu8_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 8;
    localparam int KIND_W = 2;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = 4 * DATA_W;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_STEP       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POKE       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SOFT_RESET = 2'd3;

    localparam int ZERO_FLAG_BIT = 0;

    // Opcodes
    localparam logic [DATA_W-1:0] OP_LDI = 8'h01;
    localparam logic [DATA_W-1:0] OP_LDA = 8'h02;
    localparam logic [DATA_W-1:0] OP_STA = 8'h03;
    localparam logic [DATA_W-1:0] OP_LDF = 8'h04;
    localparam logic [DATA_W-1:0] OP_STF = 8'h05;
    localparam logic [DATA_W-1:0] OP_CMP = 8'h10;
    localparam logic [DATA_W-1:0] OP_ADI = 8'h11;
    localparam logic [DATA_W-1:0] OP_ADD = 8'h12;
    localparam logic [DATA_W-1:0] OP_SUI = 8'h13;
    localparam logic [DATA_W-1:0] OP_SUB = 8'h14;
    localparam logic [DATA_W-1:0] OP_LDP = 8'h20;
    localparam logic [DATA_W-1:0] OP_JMI = 8'h21;
    localparam logic [DATA_W-1:0] OP_JMP = 8'h22;
    localparam logic [DATA_W-1:0] OP_JIZ = 8'h23;
    localparam logic [DATA_W-1:0] OP_JMZ = 8'h24;
    localparam logic [DATA_W-1:0] OP_JIN = 8'h25;
    localparam logic [DATA_W-1:0] OP_JMN = 8'h26;

endpackage

>>> src/accumulator_cpu_8bit_top.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_top
// 8-bit accumulator processor with a 256-byte unified memory, driven by
// step, peek, poke and soft reset requests over a stream interface.
// ----------------------------------------------------------------------------
// After aresetn the block zeroes its memory, one byte per cycle, with
// s_tready low. It then takes one request at a time. All memory traffic
// goes through a single port with registered read data, so the cost of a
// request is set by its chain of dependent memory accesses: a soft reset
// has none, a poke a write, a peek a read, and a step an opcode fetch, an
// operand fetch for two-byte opcodes, then an indirect read for the memory
// forms and taken memory jumps. The result sits in an output register, and
// the next request is accepted as soon as the sequencer is back in its idle state.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0: address[7:0], write_data[15:8]
    input  logic [acpu8_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: kind[1:0]
    input  logic [acpu8_pkg::KIND_W-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata fields from bit 0: program_counter[7:0], accumulator[15:8],
    // flag_bits[23:16], read_data[31:24]
    output logic [acpu8_pkg::M_TDATA_W-1:0]    m_tdata
);
    import acpu8_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PEEK,
        ST_OP,
        ST_ARG,
        ST_IND,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [DATA_W-1:0]   pc_reg, pc_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   flags_reg, flags_next;
    logic [DATA_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Single memory port
    logic [DATA_W-1:0]   mem [MEM_DEPTH];
    logic [DATA_W-1:0]   mem_q;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic [DATA_W-1:0]   mem_wdata;

    // Shared adder/subtractor
    logic                alu_sub;
    logic [DATA_W-1:0]   alu_res;
    logic                zf;

    logic [ADDR_W-1:0]   req_addr;
    logic [DATA_W-1:0]   req_wdata;

    assign req_addr  = s_tdata[ADDR_W-1:0];
    assign req_wdata = s_tdata[S_TDATA_W-1:ADDR_W];
    assign zf        = flags_reg[ZERO_FLAG_BIT];

    assign alu_res = alu_sub ? (acc_reg - mem_q) : (acc_reg + mem_q);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pc_next      = pc_reg;
        acc_next     = acc_reg;
        flags_next   = flags_reg;
        op_next      = op_reg;
        rdata_next   = rdata_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_addr     = pc_reg;
        mem_we       = 1'b0;
        mem_wdata    = acc_reg;
        alu_sub      = (op_reg == OP_SUI) || (op_reg == OP_SUB);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rdata_next = '0;
                if (s_tvalid) begin
                    case (s_tuser)
                        KIND_STEP: begin
                            mem_addr   = pc_reg;
                            pc_next    = pc_reg + 1'b1;
                            state_next = ST_OP;
                        end
                        KIND_PEEK: begin
                            mem_addr   = req_addr;
                            state_next = ST_PEEK;
                        end
                        KIND_POKE: begin
                            mem_addr   = req_addr;
                            mem_we     = 1'b1;
                            mem_wdata  = req_wdata;
                            state_next = ST_DONE;
                        end
                        default: begin
                            pc_next    = '0;
                            acc_next   = '0;
                            flags_next = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                rdata_next = mem_q;
                state_next = ST_DONE;
            end
            ST_OP: begin
                op_next    = mem_q;
                state_next = ST_DONE;
                case (mem_q)
                    OP_LDF: acc_next   = flags_reg;
                    OP_STF: flags_next = acc_reg;
                    OP_LDP: acc_next   = pc_reg;
                    OP_LDI, OP_LDA, OP_STA, OP_CMP, OP_ADI, OP_ADD, OP_SUI, OP_SUB,
                    OP_JMI, OP_JMP, OP_JIZ, OP_JMZ, OP_JIN, OP_JMN: begin
                        mem_addr   = pc_reg;
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_ARG;
                    end
                    default: ;
                endcase
            end
            ST_ARG: begin
                // mem_q holds the operand byte here.
                state_next = ST_DONE;
                case (op_reg)
                    OP_LDI: acc_next = mem_q;
                    OP_STA: begin
                        mem_addr = mem_q;
                        mem_we   = 1'b1;
                    end
                    OP_CMP: flags_next[ZERO_FLAG_BIT] = (mem_q == acc_reg);
                    OP_ADI, OP_SUI: begin
                        acc_next = alu_res;
                        flags_next[ZERO_FLAG_BIT] = (alu_res == '0);
                    end
                    OP_JMI: pc_next = mem_q;
                    OP_JIZ: if (zf) pc_next = mem_q;
                    OP_JIN: if (!zf) pc_next = mem_q;
                    OP_LDA, OP_ADD, OP_SUB, OP_JMP: begin
                        mem_addr   = mem_q;
                        state_next = ST_IND;
                    end
                    OP_JMZ: begin
                        mem_addr = mem_q;
                        if (zf) state_next = ST_IND;
                    end
                    OP_JMN: begin
                        mem_addr = mem_q;
                        if (!zf) state_next = ST_IND;
                    end
                    default: ;
                endcase
            end
            ST_IND: begin
                // mem_q holds the byte at the operand address.
                state_next = ST_DONE;
                case (op_reg)
                    OP_LDA: acc_next = mem_q;
                    OP_ADD, OP_SUB: begin
                        acc_next = alu_res;
                        flags_next[ZERO_FLAG_BIT] = (alu_res == '0);
                    end
                    OP_JMP, OP_JMZ, OP_JMN: pc_next = mem_q;
                    default: ;
                endcase
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {rdata_reg, flags_reg, acc_reg, pc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            acc_reg     <= '0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pc_reg      <= pc_next;
            acc_reg     <= acc_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        rdata_reg  <= rdata_next;
        m_data_reg <= m_data_next;
    end

endmodule
